// File: rtl/core/hbc_pkg.sv
// Package for the hall sensor BLDC commutator: word types, codes and lookup functions.
package hbc_pkg;

   typedef logic [2:0] hall_code_type;
   typedef logic [2:0] position_type;
   typedef logic [5:0] gates_type;

   typedef enum logic [1:0] {
      CMD_COAST   = 2'd0,
      CMD_FORWARD = 2'd1,
      CMD_REVERSE = 2'd2,
      CMD_BRAKE   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      MOTION_NONE = 2'd0,
      MOTION_UP   = 2'd1,
      MOTION_DOWN = 2'd2,
      MOTION_BAD  = 2'd3
   } motion_type;

   typedef struct packed {
      hall_code_type hall_sample;
      command_type   drive_command;
   } req_word_type;

   typedef struct packed {
      gates_type  gate_pattern;
      logic       hall_invalid;
      logic       hall_changed;
      motion_type motion;
   } rsp_word_type;

   localparam position_type POS_NONE = 3'd0;
   localparam position_type POS_FIRST = 3'd1;
   localparam position_type POS_LAST = 3'd6;

   // sequence position of a hall code; zero for 000 and 111
   function automatic position_type pos_of_code(input hall_code_type code);
      position_type p;
      case (code)
         3'b110:  p = 3'd1;
         3'b100:  p = 3'd2;
         3'b101:  p = 3'd3;
         3'b001:  p = 3'd4;
         3'b011:  p = 3'd5;
         3'b010:  p = 3'd6;
         default: p = POS_NONE;
      endcase
      return p;
   endfunction

   function automatic gates_type gates_of_pos(input position_type p);
      gates_type g;
      case (p)
         3'd1:    g = 6'b100100;
         3'd2:    g = 6'b100001;
         3'd3:    g = 6'b001001;
         3'd4:    g = 6'b011000;
         3'd5:    g = 6'b010010;
         3'd6:    g = 6'b000110;
         default: g = 6'b000000;
      endcase
      return g;
   endfunction

   // class of the move from one hall code to another around the six-step cycle
   function automatic motion_type classify(input hall_code_type from_code,
                                           input hall_code_type to_code);
      position_type a;
      position_type b;
      motion_type   m;
      a = pos_of_code(from_code);
      b = pos_of_code(to_code);
      if (a == POS_NONE || b == POS_NONE) begin
         m = MOTION_BAD;
      end else if (a == b) begin
         m = MOTION_NONE;
      end else if ((a != POS_LAST && b == a + 3'd1) || (a == POS_LAST && b == POS_FIRST)) begin
         m = MOTION_UP;
      end else if ((a != POS_FIRST && b == a - 3'd1) || (a == POS_FIRST && b == POS_LAST)) begin
         m = MOTION_DOWN;
      end else begin
         m = MOTION_BAD;
      end
      return m;
   endfunction

endpackage

// File: rtl/core/hall_bldc_commutator_top.sv
// Hall sensor six-step BLDC commutator: input register, lookup logic, result register.
//
//   channel | ports                          | direction | word
//   req     | req_valid, req_stall, req_word | in        | hall_sample, drive_command
//   rsp     | rsp_valid, rsp_stall, rsp_word | out       | gate_pattern, hall_invalid,
//           |                                |           | hall_changed, motion
//
// One word per cycle sustained while rsp_stall stays low; an accepted word passes the
// input register, then the result register holding the lookups and hall tracking,
// before it shows on rsp.
// Synchronous reset clears both valid flags and the hall history.
// The input register keeps taking words while a result waits under rsp_stall,
// until both registers are full; req_stall then rises.
module hall_bldc_commutator_top
   import hbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic          in_vld_ff, in_vld_in;
   req_word_type  in_word_ff;
   logic          out_vld_ff, out_vld_in;
   rsp_word_type  out_word_ff, out_word_in;
   hall_code_type latest_ff, latest_in;
   hall_code_type earlier_ff, earlier_in;
   logic          have_sample_ff, have_sample_in;
   logic          have_trans_ff, have_trans_in;

   logic          move;
   logic          req_take;
   position_type  pos;
   position_type  drive_pos;

   assign move      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !move;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_vld_in  = req_take || (in_vld_ff && !move);
      out_vld_in = move || (out_vld_ff && rsp_stall);
   end

   always_comb begin
      pos       = pos_of_code(in_word_ff.hall_sample);
      drive_pos = pos;
      case (in_word_ff.drive_command)
         CMD_FORWARD: drive_pos = (pos == POS_LAST) ? POS_FIRST : pos + 3'd1;
         CMD_REVERSE: drive_pos = (pos == POS_FIRST) ? POS_LAST : pos - 3'd1;
         default:     drive_pos = pos;
      endcase

      latest_in      = latest_ff;
      earlier_in     = earlier_ff;
      have_sample_in = have_sample_ff;
      have_trans_in  = have_trans_ff;
      out_word_in    = out_word_ff;
      if (move) begin
         out_word_in.hall_changed = 1'b0;
         if (!have_sample_ff) begin
            latest_in      = in_word_ff.hall_sample;
            have_sample_in = 1'b1;
         end else if (latest_ff != in_word_ff.hall_sample) begin
            earlier_in               = latest_ff;
            latest_in                = in_word_ff.hall_sample;
            have_trans_in            = 1'b1;
            out_word_in.hall_changed = 1'b1;
         end
         if (in_word_ff.drive_command == CMD_COAST || pos == POS_NONE) begin
            out_word_in.gate_pattern = '0;
         end else begin
            out_word_in.gate_pattern = gates_of_pos(drive_pos);
         end
         out_word_in.hall_invalid = (in_word_ff.drive_command != CMD_COAST) && (pos == POS_NONE);
         out_word_in.motion = have_trans_in ? classify(earlier_in, latest_in) : MOTION_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         out_vld_ff     <= 1'b0;
         latest_ff      <= '0;
         earlier_ff     <= '0;
         have_sample_ff <= 1'b0;
         have_trans_ff  <= 1'b0;
      end else begin
         in_vld_ff      <= in_vld_in;
         out_vld_ff     <= out_vld_in;
         latest_ff      <= latest_in;
         earlier_ff     <= earlier_in;
         have_sample_ff <= have_sample_in;
         have_trans_ff  <= have_trans_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_word_ff;

   // error word never drives the bridge
   a_invalid_gates_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.hall_invalid |-> rsp_word.gate_pattern == '0)
      else $error("gates on with invalid hall code");

   // a change always leaves a recorded transition between distinct codes
   a_change_has_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.hall_changed |-> rsp_word.motion != MOTION_NONE)
      else $error("hall change reported with no motion");

   // a held input word is not dropped
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !move |=> in_vld_ff)
      else $error("stalled input word lost");

   // history only moves when a word leaves the input register
   a_history_stable: assert property (@(posedge clock) disable iff (reset)
      !move |=> $stable(latest_ff) && $stable(earlier_ff))
      else $error("hall history changed without a word");

endmodule
